/* rtl/randomized_set_table_assert.svh */
// randomized_set_table_assert.svh: assertion macros for the randomized set table.
// Included by the top level; no other dependencies.
`ifndef RANDOMIZED_SET_TABLE_ASSERT_SVH
`define RANDOMIZED_SET_TABLE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RSET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RSET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rset_pkg.sv */
// rset_pkg.sv: shared widths, types and codes of the randomized set table.
// No dependencies.
`default_nettype none

package rset_pkg;

   localparam int CMD_W  = 2;
   localparam int VAL_W  = 32;
   localparam int RW_W   = 16;
   localparam int STAT_W = 2;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [VAL_W-1:0]  value_type;
   typedef logic [RW_W-1:0]   rword_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_SAMPLE = 2'd2;

   localparam status_type STAT_SUCCESS  = 2'd0;
   localparam status_type STAT_REFUSED  = 2'd1;
   localparam status_type STAT_CAPACITY = 2'd2;

endpackage

`default_nettype wire

/* rtl/rset_cell.sv */
// rset_cell.sv: one storage cell of the rotating entry ring.
// Depends on rset_pkg.
`default_nettype none

module rset_cell
   import rset_pkg::*;
(
   input  logic      clock,
   input  logic      shift,
   input  value_type din,
   output value_type dout
);

   value_type value_ff;
   value_type value_in;

   assign value_in = shift ? din : value_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign dout = value_ff;

endmodule

`default_nettype wire

/* rtl/rset_mod.sv */
// rset_mod.sv: bit-serial restoring remainder, random word modulo entry count.
// Depends on rset_pkg.
`default_nettype none

module rset_mod
   import rset_pkg::*;
#(
   parameter int CW = 7
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  rword_type     dividend,
   input  logic [CW-1:0] divisor,
   output logic          done,
   output logic [CW-1:0] rem
);

   localparam int CNT_W = $clog2(RW_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rword_type        dvd_ff, dvd_in;
   logic [CW-1:0]    rem_ff, rem_in;

   logic [CW:0] shifted;
   logic [CW:0] diff;
   logic        ge;

   assign shifted = {rem_ff, dvd_ff[RW_W-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign ge      = shifted >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CW-1:0] : shifted[CW-1:0];
         dvd_in = {dvd_ff[RW_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(RW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

/* rtl/randomized_set_table.sv */
// randomized_set_table.sv: top level, set of distinct values with insert, remove, sample.
// Depends on rset_pkg, rset_cell, rset_mod and randomized_set_table_assert.svh.
//
// Usage:
//   Request channel req_* (valid/stall): req_cmd is insert, remove or sample; req_value
//   is the value to insert or remove; req_random_word picks the entry on a sample.
//   Response channel rsp_* (valid/stall): one response per request, rsp_status and
//   rsp_sampled_value (zero unless a sample succeeds).
//   The entries live in a ring of CAPACITY cells that rotates one cell per cycle during
//   a sweep; a full rotation brings every entry past the head cell, where it is compared,
//   read or overwritten, and leaves the ring in its original alignment.
//   Work per request:
//     insert               one rotation
//     remove               one rotation, a second rotation when the last entry
//                          has to be moved into the freed slot
//     sample               16-step remainder unit, then one rotation
//     sample when empty,
//     unknown command      no rotation
//   One request is in flight at a time; req_stall is high until the ring is idle again,
//   so a new request is taken only once the previous one is finished.
//   A finished response waits in the output register while rsp_stall is high, and the
//   next request is taken meanwhile; its own response waits until the slot frees.
//   Reset (synchronous) empties the set and drops any pending response; cell contents
//   are not cleared since only entries below the count are ever read.
`default_nettype none

module randomized_set_table
   import rset_pkg::*;
#(
   parameter int CAPACITY = 64
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic [RW_W-1:0]          req_random_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [VAL_W-1:0]  rsp_sampled_value
);

   `include "randomized_set_table_assert.svh"

   // count holds 0..CAPACITY, cell index 0..CAPACITY-1
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_SWEEP1,
      ST_SWEEP2,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] step_ff, step_in;
   cmd_type       cmd_ff, cmd_in;
   value_type     key_ff, key_in;
   logic [CW-1:0] count_ff, count_in;
   logic          found_ff, found_in;
   logic [IW-1:0] pos_ff, pos_in;
   value_type     last_ff, last_in;
   logic [IW-1:0] idx_ff, idx_in;
   status_type    status_ff, status_in;
   value_type     sampled_ff, sampled_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   value_type     rsp_sampled_ff, rsp_sampled_in;

   // ring of cells; chain[0] is the head seen by the controller
   value_type chain [CAPACITY];
   value_type head;
   value_type wrap_value;
   logic      shift;

   logic          mod_start;
   logic          mod_done;
   logic [CW-1:0] mod_rem;

   logic [CW-1:0] step_wide;
   logic          in_range;
   logic          match;
   logic          last_step;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_tail
         rset_cell u_cell (
            .clock (clock),
            .shift (shift),
            .din   (wrap_value),
            .dout  (chain[i])
         );
      end else begin : g_body
         rset_cell u_cell (
            .clock (clock),
            .shift (shift),
            .din   (chain[i+1]),
            .dout  (chain[i])
         );
      end
   end

   rset_mod #(
      .CW (CW)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_random_word),
      .divisor  (count_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   assign head      = chain[0];
   assign step_wide = CW'(step_ff);
   assign in_range  = step_wide < count_ff;
   assign match     = in_range && (head == key_ff);
   assign last_step = step_ff == IW'(CAPACITY - 1);

   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      count_in       = count_ff;
      found_in       = found_ff;
      pos_in         = pos_ff;
      last_in        = last_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      sampled_in     = sampled_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_sampled_in = rsp_sampled_ff;
      shift          = 1'b0;
      wrap_value     = head;
      mod_start      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               key_in     = req_value;
               step_in    = '0;
               found_in   = 1'b0;
               sampled_in = '0;
               case (req_cmd)
                  CMD_INSERT, CMD_REMOVE: begin
                     state_in = ST_SWEEP1;
                  end
                  CMD_SAMPLE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_CAPACITY;
                        state_in  = ST_FINISH;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = ST_MOD;
                     end
                  end
                  default: begin
                     status_in = STAT_REFUSED;
                     state_in  = ST_FINISH;
                  end
               endcase
            end
         end

         ST_MOD: begin
            if (mod_done) begin
               idx_in   = mod_rem[IW-1:0];
               state_in = ST_SWEEP1;
            end
         end

         ST_SWEEP1: begin
            shift   = 1'b1;
            step_in = step_ff + IW'(1);
            case (cmd_ff)
               CMD_INSERT: begin
                  if (match) begin
                     found_in = 1'b1;
                  end
                  // first free slot passes the head: append unless already present
                  if (step_wide == count_ff && !found_ff) begin
                     wrap_value = key_ff;
                  end
               end
               CMD_REMOVE: begin
                  if (match) begin
                     found_in = 1'b1;
                     pos_in   = step_ff;
                  end
                  if (count_ff != '0 && step_wide == count_ff - CW'(1)) begin
                     last_in = head;
                  end
               end
               default: begin
                  if (step_ff == idx_ff) begin
                     sampled_in = head;
                  end
               end
            endcase
            if (last_step) begin
               // step restarts at zero for a second rotation
               step_in  = '0;
               state_in = ST_FINISH;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (found_in) begin
                        status_in = STAT_REFUSED;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        status_in = STAT_CAPACITY;
                     end else begin
                        status_in = STAT_SUCCESS;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (!found_in) begin
                        status_in = STAT_REFUSED;
                     end else if (CW'(pos_in) == count_ff - CW'(1)) begin
                        // removing the last entry just shrinks the count
                        status_in = STAT_SUCCESS;
                        count_in  = count_ff - CW'(1);
                     end else begin
                        state_in = ST_SWEEP2;
                     end
                  end
                  default: begin
                     status_in = STAT_SUCCESS;
                  end
               endcase
            end
         end

         ST_SWEEP2: begin
            // second rotation: drop the last entry into the freed slot
            shift   = 1'b1;
            step_in = step_ff + IW'(1);
            if (step_ff == pos_ff) begin
               wrap_value = last_ff;
            end
            if (last_step) begin
               status_in = STAT_SUCCESS;
               count_in  = count_ff - CW'(1);
               state_in  = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_sampled_in = sampled_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      found_ff       <= found_in;
      pos_ff         <= pos_in;
      last_ff        <= last_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      sampled_ff     <= sampled_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sampled_ff <= rsp_sampled_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_sampled_value = rsp_sampled_ff;

   // count stays within the ring size
   `RSET_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
      "count above capacity")
   // count only moves at the end of a rotation
   `RSET_ASSERT_NOW(a_count_move, clock, reset,
      !$past(reset) && !$stable(count_ff),
      $past(state_ff) == ST_SWEEP1 || $past(state_ff) == ST_SWEEP2,
      "count changed outside a rotation")
   // the remainder must select an occupied entry
   `RSET_ASSERT_NOW(a_mod_range, clock, reset, mod_done, mod_rem < count_ff,
      "sample index beyond count")
   // only a successful sample carries data
   `RSET_ASSERT_NOW(a_sample_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff != STAT_SUCCESS, rsp_sampled_ff == '0,
      "data on a failed response")

endmodule

`default_nettype wire
